// ----- design/fgpr_pkg.sv -----
// Shared constants, types and the 5x7 font table for the glyph pixel rasterizer.
// No dependencies; every other design file refers to this package by scoped names.
package fgpr_pkg;

    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int IDX_W   = 7;
    localparam int COL_W   = 3;
    localparam int ROW_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int BOUND_W = 13;

    localparam int CELL_W  = 6;
    localparam int CELL_H  = 8;
    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;
    localparam int GLYPH_BITS = 8 * GLYPH_W;
    localparam int FONT_N  = 95;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    localparam logic [CODE_W-1:0] FIRST_CODE = 8'h20;
    localparam logic [CODE_W-1:0] LAST_CODE  = 8'h7E;
    localparam logic [CODE_W-1:0] SUBST_CODE = 8'h3F;

    localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd1;

    typedef struct packed {
        logic [X_W-1:0]   ox;
        logic [Y_W-1:0]   oy;
        logic [IDX_W-1:0] idx;
    } t_cell;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // column 0 in the top byte, bit 0 of each byte is the top glyph row
    localparam logic [GLYPH_BITS-1:0] FONT_ROM [0:FONT_N-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008
    };

    function automatic logic glyph_bit(input logic [GLYPH_BITS-1:0] glyph,
                                       input logic [COL_W-1:0] col,
                                       input logic [ROW_W-1:0] row);
        logic [7:0] col_byte;
        col_byte = 8'h00;
        for (int c = 0; c < GLYPH_W; c++) begin
            if (col == COL_W'(c)) begin
                col_byte = glyph[GLYPH_BITS-1-8*c -: 8];
            end
        end
        glyph_bit = (col < COL_W'(GLYPH_W)) && (row < ROW_W'(GLYPH_H)) && col_byte[row];
    endfunction

endpackage

// ----- design/fgpr_front.sv -----
// Front end: takes character commands, maps codes to font entries and drops off-screen cells.
// Depends on fgpr_pkg; feeds fgpr_queue.
module fgpr_front #(
    parameter int SCREEN_WIDTH  = fgpr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fgpr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                          i_start,
    input  logic [fgpr_pkg::X_W-1:0]      i_origin_x,
    input  logic [fgpr_pkg::Y_W-1:0]      i_origin_y,
    input  logic [fgpr_pkg::CODE_W-1:0]   i_char_code,
    input  fgpr_pkg::t_q_stat             i_q_stat,
    output logic                          o_busy,
    output logic                          o_push,
    output fgpr_pkg::t_cell               o_cell
);

    logic                             fits;
    logic [fgpr_pkg::BOUND_W-1:0]     x_end;
    logic [fgpr_pkg::BOUND_W-1:0]     y_end;
    logic [fgpr_pkg::CODE_W-1:0]      code;

    always_comb begin
        x_end = fgpr_pkg::BOUND_W'(i_origin_x) + fgpr_pkg::BOUND_W'(fgpr_pkg::CELL_W);
        y_end = fgpr_pkg::BOUND_W'(i_origin_y) + fgpr_pkg::BOUND_W'(fgpr_pkg::CELL_H);
        fits  = (x_end <= fgpr_pkg::BOUND_W'(SCREEN_WIDTH))
             && (y_end <= fgpr_pkg::BOUND_W'(SCREEN_HEIGHT));
        if (i_char_code inside {[fgpr_pkg::FIRST_CODE:fgpr_pkg::LAST_CODE]}) begin
            code = i_char_code;
        end else begin
            code = fgpr_pkg::SUBST_CODE;
        end
    end

    assign o_busy     = i_q_stat.full;
    assign o_push     = i_start && !i_q_stat.full && fits;
    assign o_cell.ox  = i_origin_x;
    assign o_cell.oy  = i_origin_y;
    assign o_cell.idx = fgpr_pkg::IDX_W'(code - fgpr_pkg::FIRST_CODE);

endmodule

// ----- design/fgpr_queue.sv -----
// Short command queue between the front end and the pixel generator.
// Depends on fgpr_pkg for the cell word and status types.
module fgpr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fgpr_pkg::t_cell   i_cell,
    input  logic              i_pop,
    output fgpr_pkg::t_cell   o_cell,
    output fgpr_pkg::t_q_stat o_stat
);

    localparam int PTR_W = $clog2(fgpr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fgpr_pkg::QUEUE_DEPTH + 1);

    fgpr_pkg::t_cell   r_mem [fgpr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp  = (r_wp == PTR_W'(fgpr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            n_cnt = n_cnt + 1'b1;
        end
        if (i_pop) begin
            n_rp  = (r_rp == PTR_W'(fgpr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cell;
        end
    end

    assign o_cell       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(fgpr_pkg::QUEUE_DEPTH));

endmodule

// ----- design/fgpr_back.sv -----
// Pixel generator: walks the 6x8 cell one pixel a cycle and registers each pixel word.
// Depends on fgpr_pkg for the font table and the glyph bit lookup.
module fgpr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fgpr_pkg::t_cell               i_cell,
    input  fgpr_pkg::t_q_stat             i_q_stat,
    input  logic [fgpr_pkg::COLOR_W-1:0]  i_fg_color,
    input  logic [fgpr_pkg::COLOR_W-1:0]  i_bg_color,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [fgpr_pkg::X_W-1:0]      o_pixel_x,
    output logic [fgpr_pkg::Y_W-1:0]      o_pixel_y,
    output logic [fgpr_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic                          o_last_pixel
);

    logic                                r_act;
    logic                                r_valid;
    logic [fgpr_pkg::GLYPH_BITS-1:0]     r_glyph;
    logic [fgpr_pkg::X_W-1:0]            r_ox;
    logic [fgpr_pkg::Y_W-1:0]            r_oy;
    logic [fgpr_pkg::COL_W-1:0]          r_col;
    logic [fgpr_pkg::ROW_W-1:0]          r_row;
    logic [fgpr_pkg::X_W-1:0]            r_px;
    logic [fgpr_pkg::Y_W-1:0]            r_py;
    logic [fgpr_pkg::COLOR_W-1:0]        r_color;
    logic                                r_last;
    logic                                row_end;
    logic                                at_last;
    logic                                load;

    assign row_end = (r_col == fgpr_pkg::COL_W'(fgpr_pkg::CELL_W - 1));
    assign at_last = r_act && row_end && (r_row == fgpr_pkg::ROW_W'(fgpr_pkg::CELL_H - 1));
    assign load    = !i_q_stat.empty && (!r_act || at_last);
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= r_act;
            r_last  <= at_last;
            if (load) begin
                r_act <= 1'b1;
            end else if (at_last) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_glyph <= fgpr_pkg::FONT_ROM[i_cell.idx];
            r_ox    <= i_cell.ox;
            r_oy    <= i_cell.oy;
            r_col   <= '0;
            r_row   <= '0;
        end else if (r_act) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        r_px    <= r_ox + fgpr_pkg::X_W'(r_col);
        r_py    <= r_oy + fgpr_pkg::Y_W'(r_row);
        r_color <= fgpr_pkg::glyph_bit(r_glyph, r_col, r_row) ? i_fg_color : i_bg_color;
    end

    assign o_valid       = r_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_last_pixel  = r_valid && r_last;

endmodule

// ----- design/font_glyph_pixel_rasterizer.sv -----
// Commands pass the queue, then the generator; one pixel per cycle, 48 per cell.
// The generator takes the next queued cell at the last pixel, so cells follow with no gap.
// A two-entry queue lets up to two further commands wait; off-screen cells emit nothing.
// Reset (synchronous, low) empties the queue, stops output and restores both colors.
// Results appear on a one-cycle strobe; the receiver cannot stall them.
// Depends on fgpr_pkg, fgpr_front, fgpr_queue and fgpr_back.
module font_glyph_pixel_rasterizer #(
    parameter int SCREEN_WIDTH  = fgpr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fgpr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [fgpr_pkg::X_W-1:0]        i_origin_x,
    input  logic [fgpr_pkg::Y_W-1:0]        i_origin_y,
    input  logic [fgpr_pkg::CODE_W-1:0]     i_char_code,
    input  logic                            i_cfg_we,
    input  logic [fgpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fgpr_pkg::COLOR_W-1:0]    i_cfg_data,
    output logic                            o_valid,
    output logic [fgpr_pkg::X_W-1:0]        o_pixel_x,
    output logic [fgpr_pkg::Y_W-1:0]        o_pixel_y,
    output logic [fgpr_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic                            o_last_pixel
);

    logic [fgpr_pkg::COLOR_W-1:0] r_fg_color;
    logic [fgpr_pkg::COLOR_W-1:0] r_bg_color;
    logic                         push;
    logic                         pop;
    fgpr_pkg::t_cell              push_cell;
    fgpr_pkg::t_cell              head_cell;
    fgpr_pkg::t_q_stat            q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= fgpr_pkg::FG_RESET;
            r_bg_color <= fgpr_pkg::BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fgpr_pkg::REG_FG_COLOR: r_fg_color <= i_cfg_data;
                fgpr_pkg::REG_BG_COLOR: r_bg_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fgpr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_start     (i_start),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_char_code (i_char_code),
        .i_q_stat    (q_stat),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_cell      (push_cell)
    );

    fgpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (push_cell),
        .i_pop   (pop),
        .o_cell  (head_cell),
        .o_stat  (q_stat)
    );

    fgpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell        (head_cell),
        .i_q_stat      (q_stat),
        .i_fg_color    (r_fg_color),
        .i_bg_color    (r_bg_color),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

// ----- design/fgpr_checker.sv -----
// Port-level checks for the glyph pixel rasterizer, bound to the top level.
// Depends on fgpr_pkg for field widths.
module fgpr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_busy,
    input  logic                            o_valid,
    input  logic [fgpr_pkg::Y_W-1:0]        o_pixel_y,
    input  logic                            o_last_pixel
);

    a_last_marks_pixel: assert property (@(posedge i_clk)
        o_last_pixel |-> o_valid)
        else $error("last flag without a pixel");

    a_cell_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_pixel |=> o_valid)
        else $error("gap inside a cell");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_pixel |=>
            (o_pixel_y == $past(o_pixel_y)) || (o_pixel_y == $past(o_pixel_y) + 8'd1))
        else $error("row skipped inside a cell");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_busy)
        else $error("activity right after reset");

endmodule

bind font_glyph_pixel_rasterizer fgpr_checker u_fgpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_pixel_y    (o_pixel_y),
    .o_last_pixel (o_last_pixel)
);
